### hdl/dd_ambiguity_tracker_defines.svh
// Assertion macros for the double-difference ambiguity tracker.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef DD_AMBIGUITY_TRACKER_DEFINES_SVH
`define DD_AMBIGUITY_TRACKER_DEFINES_SVH

// same-cycle implication
`define DDA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dd_ambiguity_tracker: assertion failed");

// next-cycle implication
`define DDA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dd_ambiguity_tracker: assertion failed");

`endif

### hdl/dd_amb_pkg.sv
// Shared types and constants for the ambiguity tracker.
// No dependencies; used by dd_amb_cell and dd_ambiguity_tracker.
`timescale 1ns / 1ps

package dd_amb_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int IDX_MAX_W = 10;
	localparam int KEY_W = 18;
	localparam int BIAS_W = 48;
	localparam int CNT_W = 16;
	localparam int RATIO_W = 24;
	localparam int TIME_W = 32;
	localparam int TOL_W = 16;
	localparam int JUMP_W = 24;

	typedef logic [KEY_W-1:0] key_t;

	typedef struct packed {
		logic                 vld;
		key_t                 key;
		logic                 hit;
		logic [IDX_MAX_W-1:0] idx;
	} probe_t;

	typedef struct packed {
		logic                 en;
		logic [IDX_MAX_W-1:0] idx;
		key_t                 key;
	} insert_t;

	typedef struct packed {
		logic signed [BIAS_W-1:0] bias;
		logic signed [BIAS_W-1:0] prev_bias;
		logic [CNT_W-1:0]         count;
		logic [RATIO_W-1:0]       ratio;
		logic [TIME_W-1:0]        time_tag;
		logic [TIME_W-1:0]        prev_time;
	} entry_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_READ = 5'b00100,
		ST_DIFF = 5'b01000,
		ST_UPD  = 5'b10000
	} state_t;

	localparam logic REG_TOL = 1'b0;
	localparam logic REG_JUMP = 1'b1;

endpackage

### hdl/dd_amb_cell.sv
// One key cell of the search chain: holds a slot key and its valid bit,
// compares the passing probe and hands it on. Depends on dd_amb_pkg.
`timescale 1ns / 1ps

module dd_amb_cell #(
	parameter int CELL_ID = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dd_amb_pkg::probe_t  probe_in,
	input  dd_amb_pkg::insert_t ins,
	output dd_amb_pkg::probe_t  probe_out
);
	import dd_amb_pkg::*;

	logic   valid_q;
	key_t   key_q;
	probe_t probe_q;
	probe_t probe_d;
	logic   ins_here;

	assign ins_here = ins.en && (ins.idx == IDX_MAX_W'(CELL_ID));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ins_here) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ins_here) begin
			key_q <= ins.key;
		end
	end

	always_comb begin
		probe_d = probe_in;
		if (probe_in.vld && !probe_in.hit && valid_q && (key_q == probe_in.key)) begin
			probe_d.hit = 1'b1;
			probe_d.idx = IDX_MAX_W'(CELL_ID);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else begin
			probe_q <= probe_d;
		end
	end

	assign probe_out = probe_q;

endmodule

### hdl/dd_ambiguity_tracker.sv
// Top level of the double-difference ambiguity tracker: APB registers,
// key search chain, entry memory and update logic. Depends on dd_amb_pkg.
//
// An item is taken when start is high and busy is low. Its key travels one
// cell per cycle down a chain of TABLE_DEPTH key cells; an item then passes
// through the chain walk, one entry memory read, one difference stage and
// an update/write step. The result shows for one cycle with done high and
// cannot be held off; busy is low in that cycle, so the next item may start
// right then. A miss with a full table gives table_full with all other
// fields zero except last_out, which carries last_in_epoch.
`timescale 1ns / 1ps

module dd_ambiguity_tracker #(
	parameter int TABLE_DEPTH = dd_amb_pkg::TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  first_sat,
	input  logic [7:0]  second_sat,
	input  logic [1:0]  freq_index,
	input  logic signed [47:0] bias_value,
	input  logic        slip_first,
	input  logic        slip_second,
	input  logic [23:0] fix_ratio,
	input  logic        inherit_ratio,
	input  logic [31:0] epoch_time,
	input  logic        last_in_epoch,
	output logic        done,
	output logic [7:0]  entry_index,
	output logic        new_entry,
	output logic        table_full,
	output logic signed [47:0] held_bias,
	output logic signed [47:0] previous_bias,
	output logic [15:0] fix_count,
	output logic [23:0] ratio_out,
	output logic [31:0] prev_epoch_time,
	output logic        last_out
);
	import dd_amb_pkg::*;

	`include "dd_ambiguity_tracker_defines.svh"

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int USED_W = $clog2(TABLE_DEPTH + 1);
	localparam int DIFF_W = BIAS_W + 1;

	logic [TOL_W-1:0]  tol_q;
	logic [JUMP_W-1:0] jump_q;
	logic              cfg_wr;

	state_t state_q;
	logic   accept;

	key_t                     key_q;
	logic signed [BIAS_W-1:0] nb_q;
	logic                     slip_q;
	logic [RATIO_W-1:0]       ratio_in_q;
	logic                     inherit_q;
	logic [TIME_W-1:0]        now_q;
	logic                     last_q;

	logic [USED_W-1:0] used_q;
	logic [IDX_W-1:0]  slot_q;
	logic              hit_q;
	logic              inserted_q;

	probe_t  chain [0:TABLE_DEPTH];
	insert_t ins;

	entry_t entry_mem_q [0:TABLE_DEPTH-1];
	entry_t rd_q;
	entry_t old_ent;
	entry_t nx;
	logic [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0] d_q;
	logic              full;

	logic done_q;
	logic [7:0] index_q;
	logic new_q, full_q, lastout_q;
	entry_t res_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_JUMP) ? {8'b0, jump_q} : {16'b0, tol_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q  <= TOL_W'(66);
			jump_q <= JUMP_W'(327680);
		end else if (cfg_wr) begin
			if (paddr[2] == REG_JUMP) begin
				jump_q <= pwdata[JUMP_W-1:0];
			end else begin
				tol_q <= pwdata[TOL_W-1:0];
			end
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		chain[0].vld = accept;
		chain[0].key = {first_sat, second_sat, freq_index};
		chain[0].hit = 1'b0;
		chain[0].idx = '0;
	end

	assign full = !hit_q && (used_q == USED_W'(TABLE_DEPTH));

	always_comb begin
		ins.en  = (state_q == ST_READ) && !hit_q && !full;
		ins.idx = IDX_MAX_W'(used_q);
		ins.key = key_q;
	end

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		dd_amb_cell #(.CELL_ID(g)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.probe_in (chain[g]),
			.ins      (ins),
			.probe_out(chain[g+1])
		);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q      <= {first_sat, second_sat, freq_index};
			nb_q       <= bias_value;
			slip_q     <= slip_first || slip_second;
			ratio_in_q <= fix_ratio;
			inherit_q  <= inherit_ratio;
			now_q      <= epoch_time;
			last_q     <= last_in_epoch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			used_q     <= '0;
			hit_q      <= 1'b0;
			inserted_q <= 1'b0;
			slot_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (chain[TABLE_DEPTH].vld) begin
						hit_q   <= chain[TABLE_DEPTH].hit;
						slot_q  <= chain[TABLE_DEPTH].idx[IDX_W-1:0];
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					inserted_q <= !hit_q;
					if (full) begin
						state_q <= ST_IDLE;
					end else begin
						if (!hit_q) begin
							slot_q <= used_q[IDX_W-1:0];
							used_q <= used_q + USED_W'(1);
						end
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			rd_q <= entry_mem_q[hit_q ? slot_q : used_q[IDX_W-1:0]];
		end
		if (state_q == ST_UPD) begin
			entry_mem_q[slot_q] <= nx;
		end
	end

	assign old_ent = inserted_q ? entry_t'('0) : rd_q;
	assign diff = {old_ent.bias[BIAS_W-1], old_ent.bias} - {nb_q[BIAS_W-1], nb_q};

	always_ff @(posedge clk) begin
		if (state_q == ST_DIFF) begin
			d_q <= diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
		end
	end

	always_comb begin
		logic [DIFF_W-1:0] tol;
		logic [DIFF_W-1:0] lim;
		logic [CNT_W-1:0]  inc;
		tol = DIFF_W'(tol_q);
		lim = DIFF_W'(jump_q);
		inc = (old_ent.count == '1) ? old_ent.count : old_ent.count + CNT_W'(1);
		nx.prev_time = old_ent.time_tag;
		nx.time_tag  = now_q;
		nx.prev_bias = old_ent.bias;
		nx.bias      = nb_q;
		nx.count     = old_ent.count;
		nx.ratio     = old_ent.ratio;
		if (old_ent.count == '0) begin
			nx.count = CNT_W'(1);
		end else begin
			if (d_q < tol) begin
				nx.count = inc;
			end else if (d_q > tol) begin
				if ((d_q < lim) && (old_ent.ratio > ratio_in_q)) begin
					if (!slip_q) begin
						nx.bias  = old_ent.bias;
						nx.count = inc;
					end
				end else begin
					nx.count = '0;
				end
			end
			nx.ratio = inherit_q ? old_ent.ratio : ratio_in_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_UPD) || ((state_q == ST_READ) && full);
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_READ) && full) begin
			index_q   <= '0;
			new_q     <= 1'b0;
			full_q    <= 1'b1;
			res_q     <= '0;
			lastout_q <= last_q;
		end else if (state_q == ST_UPD) begin
			index_q   <= 8'(slot_q);
			new_q     <= inserted_q;
			full_q    <= 1'b0;
			res_q     <= nx;
			lastout_q <= last_q;
		end
	end

	assign done            = done_q;
	assign entry_index     = index_q;
	assign new_entry       = new_q;
	assign table_full      = full_q;
	assign held_bias       = res_q.bias;
	assign previous_bias   = res_q.prev_bias;
	assign fix_count       = res_q.count;
	assign ratio_out       = res_q.ratio;
	assign prev_epoch_time = res_q.prev_time;
	assign last_out        = lastout_q;

	`DDA_ASSERT_NOW(a_done_idle, done_q, state_q == ST_IDLE)
	`DDA_ASSERT_NOW(a_full_used, done_q && full_q, used_q == USED_W'(TABLE_DEPTH))
	`DDA_ASSERT_NEXT(a_accept_busy, accept, state_q == ST_SCAN)
	`DDA_ASSERT_NOW(a_chain_scan, chain[TABLE_DEPTH].vld, state_q == ST_SCAN)

endmodule
